[rtl/mwmf_pkg.sv]
// Shared constants, types and register codes of the masked window median filter.
// Used by every module of the block; depends on nothing.
package mwmf_pkg;

	localparam int PIX_W      = 16;
	localparam int MAX_PAD    = 3;
	localparam int ROWS       = 2 * MAX_PAD + 1;
	localparam int WIN        = ROWS * ROWS;
	localparam int MAX_WIDTH  = 2048;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int WID_W      = 12;
	localparam int ROW_W      = 13;
	localparam int SLOT_W     = $clog2(ROWS);
	localparam int CNT_W      = $clog2(WIN + 1);
	localparam int PAD_W      = 2;
	localparam int MASK_W     = 49;
	localparam int FIFO_DEPTH = 32;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 64;

	typedef enum logic [1:0] {
		REG_PAD    = 2'd0,
		REG_MASK   = 2'd1,
		REG_WIDTH  = 2'd2,
		REG_HEIGHT = 2'd3
	} reg_idx_t;

	typedef logic [WIN-1:0][PIX_W-1:0] win_t;

	typedef struct packed {
		logic [PAD_W-1:0] pad;
		logic [WID_W-1:0] width;
		logic [ROW_W-1:0] height;
		logic             restart;
	} cfg_t;

	typedef struct packed {
		logic [WIN-1:0]   mask;
		logic [CNT_W-1:0] half;
		logic             nz;
	} sel_cfg_t;

	typedef struct packed {
		logic             inner;
		logic             frame_end;
		logic [PIX_W-1:0] center;
	} meta_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             filtered;
		logic             frame_end;
	} res_t;

endpackage

[rtl/mwmf_csr.sv]
// Configuration registers behind the APB-style port, plus derived frame and mask settings.
// Depends on mwmf_pkg.
module mwmf_csr (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mwmf_pkg::ADDR_W-1:0]    paddr,
	input  logic [mwmf_pkg::DATA_W-1:0]    pwdata,
	output logic [mwmf_pkg::DATA_W-1:0]    prdata,
	output logic                           pready,
	output mwmf_pkg::cfg_t                 cfg,
	output mwmf_pkg::sel_cfg_t             sel_cfg
);

	logic [mwmf_pkg::PAD_W-1:0]  pad_q;
	logic [mwmf_pkg::MASK_W-1:0] mask_q;
	logic [mwmf_pkg::WID_W-1:0]  width_q;
	logic [mwmf_pkg::ROW_W-1:0]  height_q;
	logic                        wr;
	mwmf_pkg::reg_idx_t          idx;
	logic [mwmf_pkg::WIN-1:0]    exp_mask;
	logic [mwmf_pkg::CNT_W-1:0]  n_sel;

	// Place the tap mask onto the 7x7 window grid, anchored at the newest corner.
	function automatic logic [mwmf_pkg::WIN-1:0] expand_mask(
		input logic [mwmf_pkg::PAD_W-1:0]  p,
		input logic [mwmf_pkg::MASK_W-1:0] tap
	);
		logic [mwmf_pkg::WIN-1:0] m;
		m = '0;
		for (int pp = 0; pp <= mwmf_pkg::MAX_PAD; pp++) begin
			if (p == mwmf_pkg::PAD_W'(pp)) begin
				for (int rr = 0; rr < 2 * pp + 1; rr++) begin
					for (int cc = 0; cc < 2 * pp + 1; cc++) begin
						m[(mwmf_pkg::ROWS - 1 - 2 * pp + rr) * mwmf_pkg::ROWS
							+ (mwmf_pkg::ROWS - 1 - 2 * pp + cc)] = tap[rr * (2 * pp + 1) + cc];
					end
				end
			end
		end
		return m;
	endfunction

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = mwmf_pkg::reg_idx_t'(paddr[4:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q    <= mwmf_pkg::PAD_W'(1);
			mask_q   <= mwmf_pkg::MASK_W'(511);
			width_q  <= mwmf_pkg::WID_W'(640);
			height_q <= mwmf_pkg::ROW_W'(480);
		end else if (wr) begin
			case (idx)
				mwmf_pkg::REG_PAD:    pad_q    <= pwdata[mwmf_pkg::PAD_W-1:0];
				mwmf_pkg::REG_MASK:   mask_q   <= pwdata[mwmf_pkg::MASK_W-1:0];
				mwmf_pkg::REG_WIDTH:  width_q  <= pwdata[mwmf_pkg::WID_W-1:0];
				mwmf_pkg::REG_HEIGHT: height_q <= pwdata[mwmf_pkg::ROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			mwmf_pkg::REG_PAD:    prdata = mwmf_pkg::DATA_W'(pad_q);
			mwmf_pkg::REG_MASK:   prdata = mwmf_pkg::DATA_W'(mask_q);
			mwmf_pkg::REG_WIDTH:  prdata = mwmf_pkg::DATA_W'(width_q);
			mwmf_pkg::REG_HEIGHT: prdata = mwmf_pkg::DATA_W'(height_q);
			default:              prdata = '0;
		endcase
	end

	always_comb begin
		cfg.pad = pad_q;
		if (width_q == '0) begin
			cfg.width = mwmf_pkg::WID_W'(1);
		end else if (width_q > mwmf_pkg::WID_W'(mwmf_pkg::MAX_WIDTH)) begin
			cfg.width = mwmf_pkg::WID_W'(mwmf_pkg::MAX_WIDTH);
		end else begin
			cfg.width = width_q;
		end
		cfg.height  = (height_q == '0) ? mwmf_pkg::ROW_W'(1) : height_q;
		cfg.restart = wr;
	end

	always_comb begin
		exp_mask = expand_mask(pad_q, mask_q);
		n_sel    = '0;
		for (int e = 0; e < mwmf_pkg::WIN; e++) begin
			n_sel = n_sel + mwmf_pkg::CNT_W'(exp_mask[e]);
		end
	end

	// Register the selection setup (mask, half count, nonzero flag) from the pad and mask registers.
	always_ff @(posedge clk) begin
		sel_cfg.mask <= exp_mask;
		sel_cfg.half <= n_sel >> 1;
		sel_cfg.nz   <= (n_sel != '0);
	end

endmodule

[rtl/mwmf_front.sv]
// Front end: accepts transactions, tracks frame positions, holds the line stores
// and the sliding 7x7 window. Depends on mwmf_pkg.
module mwmf_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mwmf_pkg::cfg_t              cfg,
	input  logic                        acc,
	input  logic                        mode,
	input  logic [mwmf_pkg::PIX_W-1:0]  pixel_in,
	output logic                        emit,
	output logic                        win_valid,
	output mwmf_pkg::win_t              win,
	output mwmf_pkg::meta_t             win_meta
);

	localparam int ROWS = mwmf_pkg::ROWS;

	logic [mwmf_pkg::ROW_W-1:0]  in_row_q, o_row_q;
	logic [mwmf_pkg::COL_W-1:0]  in_col_q, o_col_q, q_col_q;
	logic [mwmf_pkg::SLOT_W-1:0] in_slot_q, o_slot_q, q_slot_q;
	logic                        drain_q;

	logic [mwmf_pkg::ROW_W-1:0]  cur_row, o_row_c;
	logic [mwmf_pkg::COL_W-1:0]  cur_col, o_col_c, f_col;
	logic [mwmf_pkg::SLOT_W-1:0] cur_slot, o_slot_c, f_slot;
	logic                        is_pix, t_ge, inner, last, in_wrap, complete;
	logic [2:0]                  lag_row;
	logic [1:0]                  lag_col;

	logic [mwmf_pkg::PIX_W-1:0]  line_mem [ROWS][mwmf_pkg::MAX_WIDTH];

	logic                        v_s1, inner_s1, fend_s1;
	logic [mwmf_pkg::COL_W-1:0]  fcol_s1, ccol_s1;
	logic [mwmf_pkg::SLOT_W-1:0] fslot_s1, cslot_s1;
	logic                        v_s2, inner_s2, fend_s2;
	logic [mwmf_pkg::SLOT_W-1:0] fslot_s2, cslot_s2;
	logic [mwmf_pkg::PIX_W-1:0]  rd_win_s2 [ROWS];
	logic [mwmf_pkg::PIX_W-1:0]  rd_ctr_s2 [ROWS];
	logic [mwmf_pkg::PIX_W-1:0]  rot [ROWS];
	logic [mwmf_pkg::PIX_W-1:0]  win_q [ROWS][ROWS];
	logic                        v_s3;
	mwmf_pkg::meta_t             meta_s3;

	function automatic logic [mwmf_pkg::SLOT_W-1:0] slot_inc(
		input logic [mwmf_pkg::SLOT_W-1:0] s
	);
		return (s == mwmf_pkg::SLOT_W'(ROWS - 1)) ? '0 : s + mwmf_pkg::SLOT_W'(1);
	endfunction

	// Output lag pad*width+pad as a (row, col) pair; only narrow frames carry.
	always_comb begin
		case (cfg.width)
			mwmf_pkg::WID_W'(1): begin
				lag_row = {cfg.pad, 1'b0};
				lag_col = '0;
			end
			mwmf_pkg::WID_W'(2): begin
				lag_row = 3'(cfg.pad) + 3'(cfg.pad[1]);
				lag_col = {1'b0, cfg.pad[0]};
			end
			mwmf_pkg::WID_W'(3): begin
				lag_row = 3'(cfg.pad) + 3'(cfg.pad == 2'd3);
				lag_col = (cfg.pad == 2'd3) ? 2'd0 : cfg.pad;
			end
			default: begin
				lag_row = 3'(cfg.pad);
				lag_col = cfg.pad;
			end
		endcase
	end

	always_comb begin
		is_pix = ~mode;
		if ({1'b0, in_col_q} >= cfg.width || in_row_q >= cfg.height) begin
			cur_row  = '0;
			cur_col  = '0;
			cur_slot = '0;
		end else begin
			cur_row  = in_row_q;
			cur_col  = in_col_q;
			cur_slot = in_slot_q;
		end
		t_ge = (cur_row > mwmf_pkg::ROW_W'(lag_row))
			|| (cur_row == mwmf_pkg::ROW_W'(lag_row) && cur_col >= mwmf_pkg::COL_W'(lag_col));
		emit = acc && (is_pix ? t_ge : drain_q);

		// A pixel during drain drops the old frame's remaining outputs.
		if (is_pix && drain_q) begin
			o_row_c  = '0;
			o_col_c  = '0;
			o_slot_c = '0;
		end else begin
			o_row_c  = o_row_q;
			o_col_c  = o_col_q;
			o_slot_c = o_slot_q;
		end
		f_col  = is_pix ? cur_col : q_col_q;
		f_slot = is_pix ? cur_slot : q_slot_q;

		inner = (o_row_c >= mwmf_pkg::ROW_W'(cfg.pad))
			&& (({1'b0, o_row_c} + (mwmf_pkg::ROW_W + 1)'(cfg.pad)) < {1'b0, cfg.height})
			&& (o_col_c >= mwmf_pkg::COL_W'(cfg.pad))
			&& (({1'b0, o_col_c} + mwmf_pkg::WID_W'(cfg.pad)) < cfg.width);
		last = (o_row_c == cfg.height - mwmf_pkg::ROW_W'(1))
			&& ({1'b0, o_col_c} == cfg.width - mwmf_pkg::WID_W'(1));
		in_wrap  = ({1'b0, cur_col} + mwmf_pkg::WID_W'(1)) == cfg.width;
		complete = in_wrap && ((cur_row + mwmf_pkg::ROW_W'(1)) == cfg.height);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			in_slot_q <= '0;
			o_row_q   <= '0;
			o_col_q   <= '0;
			o_slot_q  <= '0;
			q_col_q   <= '0;
			q_slot_q  <= '0;
			drain_q   <= 1'b0;
		end else if (cfg.restart) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			in_slot_q <= '0;
			o_row_q   <= '0;
			o_col_q   <= '0;
			o_slot_q  <= '0;
			drain_q   <= 1'b0;
		end else if (acc) begin
			if (is_pix) begin
				if (in_wrap) begin
					in_col_q <= '0;
					if (complete) begin
						in_row_q  <= '0;
						in_slot_q <= '0;
					end else begin
						in_row_q  <= cur_row + mwmf_pkg::ROW_W'(1);
						in_slot_q <= slot_inc(cur_slot);
					end
				end else begin
					in_row_q  <= cur_row;
					in_slot_q <= cur_slot;
					in_col_q  <= cur_col + mwmf_pkg::COL_W'(1);
				end
				drain_q <= complete && !(emit && last);
			end else if (emit && last) begin
				drain_q <= 1'b0;
			end
			if (emit) begin
				if (last) begin
					o_row_q  <= '0;
					o_col_q  <= '0;
					o_slot_q <= '0;
				end else if (({1'b0, o_col_c} + mwmf_pkg::WID_W'(1)) == cfg.width) begin
					o_col_q  <= '0;
					o_row_q  <= o_row_c + mwmf_pkg::ROW_W'(1);
					o_slot_q <= slot_inc(o_slot_c);
				end else begin
					o_row_q  <= o_row_c;
					o_slot_q <= o_slot_c;
					o_col_q  <= o_col_c + mwmf_pkg::COL_W'(1);
				end
				if (({1'b0, f_col} + mwmf_pkg::WID_W'(1)) == cfg.width) begin
					q_col_q  <= '0;
					q_slot_q <= slot_inc(f_slot);
				end else begin
					q_col_q  <= f_col + mwmf_pkg::COL_W'(1);
					q_slot_q <= f_slot;
				end
			end else if (is_pix && drain_q) begin
				o_row_q  <= '0;
				o_col_q  <= '0;
				o_slot_q <= '0;
			end
		end
	end

	// Line stores: one write port, two read ports (window column and center).
	always_ff @(posedge clk) begin
		if (acc && is_pix) begin
			line_mem[cur_slot][cur_col] <= pixel_in;
		end
		for (int s = 0; s < ROWS; s++) begin
			rd_win_s2[s] <= line_mem[s][fcol_s1];
			rd_ctr_s2[s] <= line_mem[s][ccol_s1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= emit;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		fcol_s1  <= f_col;
		fslot_s1 <= f_slot;
		ccol_s1  <= o_col_c;
		cslot_s1 <= o_slot_c;
		inner_s1 <= inner;
		fend_s1  <= last;
		fslot_s2 <= fslot_s1;
		cslot_s2 <= cslot_s1;
		inner_s2 <= inner_s1;
		fend_s2  <= fend_s1;
		meta_s3.inner     <= inner_s2;
		meta_s3.frame_end <= fend_s2;
		meta_s3.center    <= rd_ctr_s2[cslot_s2];
	end

	// Window row j holds line rq-6+j, whose slot is one past the fetched slot plus j.
	always_comb begin
		for (int j = 0; j < ROWS; j++) begin
			logic [mwmf_pkg::SLOT_W:0] sidx;
			sidx = {1'b0, fslot_s2} + (mwmf_pkg::SLOT_W + 1)'(j + 1);
			if (sidx >= (mwmf_pkg::SLOT_W + 1)'(ROWS)) begin
				sidx = sidx - (mwmf_pkg::SLOT_W + 1)'(ROWS);
			end
			rot[j] = rd_win_s2[sidx[mwmf_pkg::SLOT_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			for (int j = 0; j < ROWS; j++) begin
				for (int c = 0; c < ROWS - 1; c++) begin
					win_q[j][c] <= win_q[j][c + 1];
				end
				win_q[j][ROWS - 1] <= rot[j];
			end
		end
	end

	always_comb begin
		for (int j = 0; j < ROWS; j++) begin
			for (int c = 0; c < ROWS; c++) begin
				win[j * ROWS + c] = win_q[j][c];
			end
		end
	end

	assign win_valid = v_s3;
	assign win_meta  = meta_s3;

endmodule

[rtl/mwmf_select.sv]
// Back end: pipelined radix selection, one pixel bit per stage, of the masked median.
// Depends on mwmf_pkg.
module mwmf_select (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  mwmf_pkg::win_t        win,
	input  mwmf_pkg::meta_t       meta,
	input  mwmf_pkg::sel_cfg_t    sel_cfg,
	output logic                  res_valid,
	output mwmf_pkg::res_t        res
);

	localparam int NST = mwmf_pkg::PIX_W;

	typedef struct packed {
		mwmf_pkg::meta_t                meta;
		mwmf_pkg::win_t                 win;
		logic [mwmf_pkg::WIN-1:0]       cand;
		logic [mwmf_pkg::CNT_W-1:0]     k;
		logic [mwmf_pkg::PIX_W-1:0]     val;
	} stage_t;

	stage_t cur [NST];
	stage_t nxt [NST];
	stage_t st_s [NST];
	logic   vld_s [NST];

	always_comb begin
		cur[0].meta = meta;
		cur[0].win  = win;
		cur[0].cand = sel_cfg.mask;
		cur[0].k    = sel_cfg.half;
		cur[0].val  = '0;
		for (int i = 1; i < NST; i++) begin
			cur[i] = st_s[i - 1];
		end
	end

	for (genvar i = 0; i < NST; i++) begin : g_stage
		localparam int B = mwmf_pkg::PIX_W - 1 - i;

		always_comb begin
			logic [mwmf_pkg::WIN-1:0]   ones;
			logic [mwmf_pkg::WIN-1:0]   zeros;
			logic [mwmf_pkg::CNT_W-1:0] cnt0;
			for (int e = 0; e < mwmf_pkg::WIN; e++) begin
				ones[e] = cur[i].win[e][B];
			end
			zeros = cur[i].cand & ~ones;
			cnt0  = '0;
			for (int e = 0; e < mwmf_pkg::WIN; e++) begin
				cnt0 = cnt0 + mwmf_pkg::CNT_W'(zeros[e]);
			end
			nxt[i] = cur[i];
			if (cur[i].k < cnt0) begin
				nxt[i].cand   = zeros;
				nxt[i].val[B] = 1'b0;
			end else begin
				nxt[i].cand   = cur[i].cand & ones;
				nxt[i].k      = cur[i].k - cnt0;
				nxt[i].val[B] = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			st_s[i] <= nxt[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else begin
				vld_s[i] <= (i == 0) ? in_valid : vld_s[(i == 0) ? 0 : i - 1];
			end
		end
	end

	always_comb begin
		res_valid     = vld_s[NST - 1];
		res.filtered  = st_s[NST - 1].meta.inner && sel_cfg.nz;
		res.pixel     = res.filtered ? st_s[NST - 1].val : st_s[NST - 1].meta.center;
		res.frame_end = st_s[NST - 1].meta.frame_end;
	end

endmodule

[rtl/mwmf_fifo.sv]
// Result queue between the selection pipeline and the output channel.
// Depends on mwmf_pkg.
module mwmf_fifo (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  mwmf_pkg::res_t               push_data,
	input  logic                         pop,
	output logic                         valid,
	output mwmf_pkg::res_t               data,
	output logic [mwmf_pkg::FIFO_AW:0]   count
);

	mwmf_pkg::res_t                mem [mwmf_pkg::FIFO_DEPTH];
	logic [mwmf_pkg::FIFO_AW-1:0]  wr_q, rd_q;
	logic [mwmf_pkg::FIFO_AW:0]    cnt_q;
	logic                          do_pop;

	assign valid  = (cnt_q != '0);
	assign data   = mem[rd_q];
	assign count  = cnt_q;
	assign do_pop = pop && valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + mwmf_pkg::FIFO_AW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + mwmf_pkg::FIFO_AW'(1);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + (mwmf_pkg::FIFO_AW + 1)'(1);
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - (mwmf_pkg::FIFO_AW + 1)'(1);
			end
		end
	end

endmodule

[rtl/masked_window_median_filter.sv]
// Masked window median filter, top level.
// Path: the result of an accepted pixel (or drain tick) passes the front-end window registers,
// the 16-stage selection pipe and the result queue before it appears on the output. Throughput
// one transaction per cycle while a credit of the 32-entry result queue is free (input stalls
// when all are taken); the selection pipe and line-store ports are all fully pipelined.
// Reset: arst_n clears positions, drain flag, credits and queue; registers return to pad 1,
// mask 511, 640x480. Line stores and window come up undefined and need no clearing pass.
module masked_window_median_filter (
	input  logic                           clk,
	input  logic                           arst_n,
	// APB-style configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mwmf_pkg::ADDR_W-1:0]    paddr,
	input  logic [mwmf_pkg::DATA_W-1:0]    pwdata,
	output logic [mwmf_pkg::DATA_W-1:0]    prdata,
	output logic                           pready,
	// input stream
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           mode,
	input  logic [mwmf_pkg::PIX_W-1:0]     pixel_in,
	// output stream
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [mwmf_pkg::PIX_W-1:0]     pixel_out,
	output logic                           was_filtered,
	output logic                           frame_end
);

	mwmf_pkg::cfg_t               cfg;
	mwmf_pkg::sel_cfg_t           sel_cfg;
	logic                         acc, emit, win_valid, sel_valid, pop;
	mwmf_pkg::win_t               win;
	mwmf_pkg::meta_t              win_meta;
	mwmf_pkg::res_t               sel_res, q_res;
	logic [mwmf_pkg::FIFO_AW:0]   fifo_cnt;
	logic [mwmf_pkg::FIFO_AW:0]   credit_q;

	// Credits count every result in flight or queued; hold input while the queue could fill.
	assign in_ready = (credit_q < (mwmf_pkg::FIFO_AW + 1)'(mwmf_pkg::FIFO_DEPTH));
	assign acc      = in_valid && in_ready;
	assign pop      = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if (emit && !pop) begin
			credit_q <= credit_q + (mwmf_pkg::FIFO_AW + 1)'(1);
		end else if (pop && !emit) begin
			credit_q <= credit_q - (mwmf_pkg::FIFO_AW + 1)'(1);
		end
	end

	// Registers and derived frame geometry / tap layout.
	mwmf_csr u_csr (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.sel_cfg (sel_cfg)
	);

	// Front: classify pixel vs drain, advance positions, write line stores, slide window.
	mwmf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.acc       (acc),
		.mode      (mode),
		.pixel_in  (pixel_in),
		.emit      (emit),
		.win_valid (win_valid),
		.win       (win),
		.win_meta  (win_meta)
	);

	// Back: bit-serial-in-space median selection, one bit per stage.
	mwmf_select u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (win_valid),
		.win       (win),
		.meta      (win_meta),
		.sel_cfg   (sel_cfg),
		.res_valid (sel_valid),
		.res       (sel_res)
	);

	// Result queue decouples the pipe from output stalls.
	mwmf_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (sel_valid),
		.push_data (sel_res),
		.pop       (pop),
		.valid     (out_valid),
		.data      (q_res),
		.count     (fifo_cnt)
	);

	assign pixel_out    = q_res.pixel;
	assign was_filtered = q_res.filtered;
	assign frame_end    = q_res.frame_end;

	// Queued results never exceed outstanding credits.
	a_credit_covers_queue: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt <= credit_q)
		else $error("result queue holds more than the credit count");

	// A result never arrives at a full queue unless a result leaves in the same cycle.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		sel_valid |-> (fifo_cnt < (mwmf_pkg::FIFO_AW + 1)'(mwmf_pkg::FIFO_DEPTH) || pop))
		else $error("result pushed into a full queue");

	// After an emitting transaction the credit count is never zero.
	a_emit_has_credit: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (credit_q != '0))
		else $error("credit count lost an emitted result");

endmodule
